// ===== rtl/core/spr_pkg.sv =====
`timescale 1ns / 1ps

package spr_pkg;

    // Field widths
    localparam int POS_W  = 32;
    localparam int YAW_W  = 16;
    localparam int TRIG_W = 16;
    localparam int STEP_W = 10;

    // CORDIC datapath, signed Q2.30 with headroom
    localparam int XY_W = 34;
    localparam int Z_W  = 32;
    localparam int ATAN_LEN = 24;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032875);

    // Multiply-accumulate datapath
    localparam int PROD_W = POS_W + TRIG_W;
    localparam int DIFF_W = POS_W + 1;
    localparam int ACC_W  = 50;

    // Accumulator targets
    localparam logic [1:0] SEL_RES_X = 2'd0;
    localparam logic [1:0] SEL_RES_Y = 2'd1;
    localparam logic [1:0] SEL_YAW_X = 2'd2;
    localparam logic [1:0] SEL_YAW_Y = 2'd3;

    localparam int MAC_OPS = 8;

    typedef struct packed {
        logic       coef_sin;  // 1: sine operand, 0: cosine operand
        logic       data_ry;   // 1: rel_y operand, 0: rel_x operand
        logic       neg;       // subtract the product
        logic       first;     // start a new sum from its base
        logic       last;      // sum complete after this product
        logic [1:0] sel;       // target output
    } t_mac_op;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig;

    // Arctangent of 2^-i in units of 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10679838;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Product schedule: two products per output sum
    function automatic t_mac_op mac_op(input logic [2:0] k);
        t_mac_op op;
        unique case (k)
            3'd0: op = '{coef_sin: 1'b0, data_ry: 1'b0, neg: 1'b1, first: 1'b1, last: 1'b0,
                         sel: SEL_RES_X};
            3'd1: op = '{coef_sin: 1'b1, data_ry: 1'b1, neg: 1'b0, first: 1'b0, last: 1'b1,
                         sel: SEL_RES_X};
            3'd2: op = '{coef_sin: 1'b1, data_ry: 1'b0, neg: 1'b1, first: 1'b1, last: 1'b0,
                         sel: SEL_RES_Y};
            3'd3: op = '{coef_sin: 1'b0, data_ry: 1'b1, neg: 1'b1, first: 1'b0, last: 1'b1,
                         sel: SEL_RES_Y};
            3'd4: op = '{coef_sin: 1'b1, data_ry: 1'b0, neg: 1'b0, first: 1'b1, last: 1'b0,
                         sel: SEL_YAW_X};
            3'd5: op = '{coef_sin: 1'b0, data_ry: 1'b1, neg: 1'b0, first: 1'b0, last: 1'b1,
                         sel: SEL_YAW_X};
            3'd6: op = '{coef_sin: 1'b1, data_ry: 1'b1, neg: 1'b0, first: 1'b1, last: 1'b0,
                         sel: SEL_YAW_Y};
            3'd7: op = '{coef_sin: 1'b0, data_ry: 1'b0, neg: 1'b1, first: 1'b0, last: 1'b1,
                         sel: SEL_YAW_Y};
            default: op = '0;
        endcase
        return op;
    endfunction

endpackage

// ===== rtl/core/spr_cordic.sv =====
`timescale 1ns / 1ps

module spr_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [spr_pkg::YAW_W-1:0]     i_yaw,
    output logic                          o_done,
    output spr_pkg::t_trig                o_trig
);
    import spr_pkg::*;

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] LAST_I = CNT_W'(CORDIC_STEPS - 1);
    localparam logic signed [XY_W:0] Q_MAX = (XY_W+1)'(16384);
    localparam logic signed [XY_W:0] Q_MIN = -(XY_W+1)'(16384);

    logic [YAW_W:0]           w_fold;
    logic signed [13:0]       w_resid;
    logic signed [XY_W-1:0]   w_dx, w_dy, n_x, n_y;
    logic signed [Z_W-1:0]    w_at, n_z;
    logic signed [TRIG_W-1:0] w_c, w_s;

    logic                   r_busy, r_fin, r_done;
    logic [CNT_W-1:0]       r_i;
    logic [1:0]             r_q;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    t_trig                  r_trig;

    // Round Q2.30 to Q1.14 and clamp to one.
    function automatic logic signed [TRIG_W-1:0] rnd_q14(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] t;
        t = (XY_W+1)'(v) + (XY_W+1)'(32768);
        t = t >>> 16;
        if (t > Q_MAX) begin
            t = Q_MAX;
        end else if (t < Q_MIN) begin
            t = Q_MIN;
        end
        return TRIG_W'(t);
    endfunction

    // Fold the angle to the quadrant nearest zero.
    assign w_fold  = (YAW_W+1)'(i_yaw) + (YAW_W+1)'(8192);
    assign w_resid = {~w_fold[13], w_fold[12:0]};

    always_comb begin
        w_dx = r_y >>> r_i;
        w_dy = r_x >>> r_i;
        w_at = atan_lut(5'(r_i));
        if (!r_z[Z_W-1]) begin
            n_x = r_x - w_dx;
            n_y = r_y + w_dy;
            n_z = r_z - w_at;
        end else begin
            n_x = r_x + w_dx;
            n_y = r_y - w_dy;
            n_z = r_z + w_at;
        end
    end

    assign w_c = rnd_q14(r_x);
    assign w_s = rnd_q14(r_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_fin  <= 1'b0;
            r_done <= r_fin;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == LAST_I) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= w_fold[15:14];
            r_x <= CORDIC_GAIN;
            r_y <= '0;
            r_z <= {{(Z_W-30){w_resid[13]}}, w_resid, 16'h0000};
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        // Map the rotated pair back to its quadrant.
        if (r_fin) begin
            case (r_q)
                2'd1: begin
                    r_trig.cos_v <= -w_s;
                    r_trig.sin_v <= w_c;
                end
                2'd2: begin
                    r_trig.cos_v <= -w_c;
                    r_trig.sin_v <= -w_s;
                end
                2'd3: begin
                    r_trig.cos_v <= w_s;
                    r_trig.sin_v <= -w_c;
                end
                default: begin
                    r_trig.cos_v <= w_c;
                    r_trig.sin_v <= w_s;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_trig = r_trig;

endmodule

// ===== rtl/core/spr_mac.sv =====
`timescale 1ns / 1ps

module spr_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_op_vld,
    input  spr_pkg::t_mac_op                     i_op,
    input  logic signed [spr_pkg::TRIG_W-1:0]    i_coef,
    input  logic signed [spr_pkg::POS_W-1:0]     i_data,
    input  logic signed [spr_pkg::DIFF_W-1:0]    i_dx,
    input  logic signed [spr_pkg::DIFF_W-1:0]    i_dy,
    output logic                                 o_res_vld,
    output logic [1:0]                           o_res_sel,
    output logic signed [spr_pkg::POS_W-1:0]     o_res
);
    import spr_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(8192);
    localparam logic signed [ACC_W-15:0] SAT_MAX = (ACC_W-14)'(2147483647);
    localparam logic signed [ACC_W-15:0] SAT_MIN = -(ACC_W-14)'(2147483647) - (ACC_W-14)'(1);

    logic signed [ACC_W-1:0]  w_base, w_term, w_rnd;
    logic signed [ACC_W-15:0] w_shr;

    logic                     r_v1, r_v2, r_v3;
    t_mac_op                  r_op1;
    logic [1:0]               r_sel2, r_sel3;
    logic signed [PROD_W-1:0] r_p;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [POS_W-1:0]  r_res;

    // Open a sum from the position difference in Q16.30 (zero for the yaw terms), or continue it.
    always_comb begin
        if (r_op1.first) begin
            case (r_op1.sel)
                SEL_RES_X: w_base = ACC_W'(i_dx) <<< 14;
                SEL_RES_Y: w_base = ACC_W'(i_dy) <<< 14;
                default:   w_base = '0;
            endcase
        end else begin
            w_base = r_acc;
        end
        w_term = r_op1.neg ? -ACC_W'(r_p) : ACC_W'(r_p);
    end

    // Round once to Q16.16 and saturate.
    always_comb begin
        w_rnd = r_acc + RND_HALF;
        w_shr = (ACC_W-14)'(w_rnd >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_op_vld;
            r_v2 <= r_v1 & r_op1.last;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= i_coef * i_data;
        r_op1  <= i_op;
        if (r_v1) begin
            r_acc <= w_base + w_term;
        end
        r_sel2 <= r_op1.sel;
        r_sel3 <= r_sel2;
        if (w_shr > SAT_MAX) begin
            r_res <= POS_W'(SAT_MAX);
        end else if (w_shr < SAT_MIN) begin
            r_res <= POS_W'(SAT_MIN);
        end else begin
            r_res <= POS_W'(w_shr);
        end
    end

    assign o_res_vld = r_v3;
    assign o_res_sel = r_sel3;
    assign o_res     = r_res;

endmodule

// ===== rtl/core/planar_step_pose_residual_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents (lowest bits first)
// s_axis    in   144+1  tdata: step_x, step_y, step_yaw, rel_x, rel_y; tuser: first_step
// m_axis    out  176    tdata: step_index, residual_x, residual_y, yaw_term_x,
//                       yaw_term_y, cos_prev_yaw, sin_prev_yaw, zero fill
//
// A first step (or any step with no stored pose) is only stored and gives no result.
// Any other step holds s_axis_tready low while it runs CORDIC_STEPS iterations of the
// CORDIC rotator, rounds and hands over sin and cos, issues eight products through the
// one 16x32 multiplier, drains its three-stage accumulator and loads the output register.
// The result sits in an output register, so a stalled m_axis only blocks the
// following step once its own result is ready.
// Reset (synchronous, active low) discards the stored pose and clears the step count and m_axis_tvalid.

module planar_step_pose_residual_core #(
    parameter int CORDIC_STEPS = 16,
    parameter int MAX_STEPS    = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,  // step_x, step_y, step_yaw, rel_x, rel_y
    input  logic [0:0]   s_axis_tuser,  // first_step
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [175:0] m_axis_tdata   // step_index, residual_x, residual_y, yaw_term_x,
                                        // yaw_term_y, cos_prev_yaw, sin_prev_yaw, 0
);
    import spr_pkg::*;

    localparam int CAP = (MAX_STEPS - 1 > 1023) ? 1023 : MAX_STEPS - 1;
    localparam logic [STEP_W-1:0] CAP_V = STEP_W'(CAP);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CORDIC = 4'b0010,
        S_MAC    = 4'b0100,
        S_OUT    = 4'b1000
    } t_state;

    // Unpacked request fields
    logic                    w_first;
    logic signed [POS_W-1:0] w_step_x, w_step_y, w_rel_x, w_rel_y;
    logic [YAW_W-1:0]        w_step_yaw;

    logic w_accept, w_restart, w_start, w_load;

    t_state                   r_state;
    logic                     r_have_prev;
    logic [STEP_W-1:0]        r_count;
    logic signed [POS_W-1:0]  r_prev_x, r_prev_y;
    logic [YAW_W-1:0]         r_prev_yaw;
    logic signed [DIFF_W-1:0] r_dx, r_dy;
    logic signed [POS_W-1:0]  r_rx, r_ry;
    t_trig                    r_trig;
    logic [2:0]               r_k;
    logic                     r_k_done;
    logic signed [POS_W-1:0]  r_res_x, r_res_y, r_yaw_x, r_yaw_y;
    logic                     r_out_vld;
    logic [175:0]             r_out;

    logic                     w_cordic_done;
    t_trig                    w_trig;
    logic                     w_op_vld;
    t_mac_op                  w_op;
    logic signed [TRIG_W-1:0] w_coef;
    logic signed [POS_W-1:0]  w_data;
    logic                     w_res_vld;
    logic [1:0]               w_res_sel;
    logic signed [POS_W-1:0]  w_res;

    assign w_first    = s_axis_tuser[0];
    assign w_step_x   = s_axis_tdata[31:0];
    assign w_step_y   = s_axis_tdata[63:32];
    assign w_step_yaw = s_axis_tdata[79:64];
    assign w_rel_x    = s_axis_tdata[111:80];
    assign w_rel_y    = s_axis_tdata[143:112];

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    // A new plan, or no stored pose yet: store only.
    assign w_restart     = w_first | ~r_have_prev;
    assign w_start       = w_accept & ~w_restart;
    // Move the finished result into the output register once it is free.
    assign w_load        = (r_state == S_OUT) & (~r_out_vld | m_axis_tready);

    spr_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_yaw   (r_prev_yaw),
        .o_done  (w_cordic_done),
        .o_trig  (w_trig)
    );

    // Issue one product per cycle from the fixed schedule.
    assign w_op_vld = (r_state == S_MAC) & ~r_k_done;
    assign w_op     = mac_op(r_k);
    assign w_coef   = w_op.coef_sin ? r_trig.sin_v : r_trig.cos_v;
    assign w_data   = w_op.data_ry ? r_ry : r_rx;

    spr_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op_vld  (w_op_vld),
        .i_op      (w_op),
        .i_coef    (w_coef),
        .i_data    (w_data),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .o_res_vld (w_res_vld),
        .o_res_sel (w_res_sel),
        .o_res     (w_res)
    );

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_count     <= '0;
            r_k         <= '0;
            r_k_done    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            // Present a newly loaded result, or drop the one just taken.
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_have_prev <= 1'b1;
                        if (w_restart) begin
                            r_count <= '0;
                        end else begin
                            if (r_count < CAP_V) begin
                                r_count <= r_count + 1'b1;
                            end
                            r_state <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC: begin
                    if (w_cordic_done) begin
                        r_k      <= '0;
                        r_k_done <= 1'b0;
                        r_state  <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (!r_k_done) begin
                        r_k <= r_k + 1'b1;
                        if (r_k == 3'(MAC_OPS - 1)) begin
                            r_k_done <= 1'b1;
                        end
                    end
                    if (w_res_vld && w_res_sel == SEL_YAW_Y) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_prev_x   <= w_step_x;
            r_prev_y   <= w_step_y;
            r_prev_yaw <= w_step_yaw;
            r_dx       <= DIFF_W'(w_step_x) - DIFF_W'(r_prev_x);
            r_dy       <= DIFF_W'(w_step_y) - DIFF_W'(r_prev_y);
            r_rx       <= w_rel_x;
            r_ry       <= w_rel_y;
        end
        if (r_state == S_CORDIC && w_cordic_done) begin
            r_trig <= w_trig;
        end
        if (w_res_vld) begin
            case (w_res_sel)
                SEL_RES_X: r_res_x <= w_res;
                SEL_RES_Y: r_res_y <= w_res;
                SEL_YAW_X: r_yaw_x <= w_res;
                default:   r_yaw_y <= w_res;
            endcase
        end
        if (w_load) begin
            r_out <= {6'b000000, r_trig.sin_v, r_trig.cos_v, r_yaw_y, r_yaw_x,
                      r_res_y, r_res_x, r_count};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    // A trig result only arrives while the sequencer waits for it.
    a_cordic_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cordic_done |-> (r_state == S_CORDIC))
        else $error("trig result outside the rotation phase");

    // Finished sums only appear during the multiply phase.
    a_mac_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_vld |-> (r_state == S_MAC))
        else $error("sum result outside the multiply phase");

    // The block does not take a request while a result is being assembled.
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_OUT) |-> !s_axis_tready)
        else $error("request accepted while busy");

    // A load always presents a result in the next cycle.
    a_load_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // Every result carries a step index between one and the cap.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[9:0] != '0 && m_axis_tdata[9:0] <= CAP_V))
        else $error("step index out of range");

endmodule

// ===== bench/planar_step_pose_residual_core_tb.sv =====
`timescale 1ns / 1ps

module planar_step_pose_residual_core_tb;
    import spr_pkg::*;

    localparam int CORDIC_N  = 16;
    localparam int MAX_STEPS = 1024;
    localparam int STEP_CAP  = (MAX_STEPS - 1 > 1023) ? 1023 : MAX_STEPS - 1;
    localparam int LIMIT     = 1000000;
    localparam int N_RANDOM  = 1900;

    localparam logic signed [POS_W-1:0] P_MAX = 32'sh7FFFFFFF;
    localparam logic signed [POS_W-1:0] P_MIN = 32'sh80000000;
    localparam logic signed [POS_W-1:0] ONE_M = 32'sh00010000;

    // One footstep request as it enters the block
    typedef struct {
        logic                    first;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [YAW_W-1:0]        yaw;
        logic signed [POS_W-1:0] rx;
        logic signed [POS_W-1:0] ry;
        int                      gap;    // idle cycles before it is offered
        bit                      drain;  // hold it until every residual is back
    } t_step_req;

    typedef struct packed {
        logic [STEP_W-1:0]        idx;
        logic signed [POS_W-1:0]  res_x;
        logic signed [POS_W-1:0]  res_y;
        logic signed [POS_W-1:0]  yaw_x;
        logic signed [POS_W-1:0]  yaw_y;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_pose_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata = '0;   // step_x, step_y, step_yaw, rel_x, rel_y
    logic [0:0]   s_axis_tuser = '0;   // first_step
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [175:0] m_axis_tdata;        // step_index, residual_x, residual_y, yaw_term_x,
                                       // yaw_term_y, cos_prev_yaw, sin_prev_yaw, 0

    planar_step_pose_residual_core #(
        .CORDIC_STEPS(CORDIC_N),
        .MAX_STEPS   (MAX_STEPS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    t_step_req step_q[$];
    t_pose_res residual_q[$];
    int        n_errors = 0;
    int        n_queued = 0;
    int        n_results = 0;
    int        cycle_cnt = 0;

    // Predicted pose memory of the block
    logic signed [POS_W-1:0] pv_x = '0;
    logic signed [POS_W-1:0] pv_y = '0;
    logic [YAW_W-1:0]        pv_yaw = '0;
    logic                    pv_valid = 1'b0;
    logic [STEP_W-1:0]       pv_count = '0;

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at result %0d: %s got %0d want %0d", n_results, what, got, want);
        n_errors++;
    endtask

    // Arctangent of 2^-i, 2^32 units per turn
    function automatic longint arc_step(input int i);
        case (i)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10679838;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            23: return 81;
            default: return 0;
        endcase
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic logic signed [POS_W-1:0] round_q14(input longint v);
        return POS_W'(clip((v + 8192) >>> 14, -64'sd2147483648, 64'sd2147483647));
    endfunction

    // Fold to a quadrant, rotate the residual angle, round to Q1.14, unfold
    function automatic void yaw_sincos(input logic [YAW_W-1:0] yaw,
                                       output longint c_out, output longint s_out);
        logic [YAW_W-1:0] sh;
        logic [1:0]       quad;
        longint           z, x, y, dx, dy, c, s;
        int               n;
        sh   = yaw + 16'd8192;
        quad = sh[15:14];
        z    = (longint'(sh[13:0]) - 8192) * 65536;
        x    = 652032875;
        y    = 0;
        n    = (CORDIC_N > 24) ? 24 : CORDIC_N;
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - arc_step(i);
            end else begin
                x = x + dx; y = y - dy; z = z + arc_step(i);
            end
        end
        c = clip((x + 32768) >>> 16, -16384, 16384);
        s = clip((y + 32768) >>> 16, -16384, 16384);
        case (quad)
            2'd1: begin c_out = -s; s_out = c; end
            2'd2: begin c_out = -c; s_out = -s; end
            2'd3: begin c_out = s; s_out = -c; end
            default: begin c_out = c; s_out = s; end
        endcase
    endfunction

    // Update the pose memory; return 1 with the residual when the step makes one
    function automatic bit project_step(input t_step_req rq, output t_pose_res res);
        longint co, si, rx, ry, px, py;
        res = '0;
        if (rq.first || !pv_valid) begin
            pv_x = rq.sx; pv_y = rq.sy; pv_yaw = rq.yaw;
            pv_valid = 1'b1; pv_count = '0;
            return 1'b0;
        end
        yaw_sincos(pv_yaw, co, si);
        rx = rq.rx;
        ry = rq.ry;
        px = co * rx - si * ry;
        py = si * rx + co * ry;
        if (pv_count < STEP_CAP) pv_count = pv_count + 1'b1;
        res.idx   = pv_count;
        res.res_x = round_q14((longint'(rq.sx) - longint'(pv_x)) * 16384 - px);
        res.res_y = round_q14((longint'(rq.sy) - longint'(pv_y)) * 16384 - py);
        res.yaw_x = round_q14(rx * si + ry * co);
        res.yaw_y = round_q14(ry * si - rx * co);
        res.cos_v = TRIG_W'(co);
        res.sin_v = TRIG_W'(si);
        pv_x = rq.sx; pv_y = rq.sy; pv_yaw = rq.yaw;
        return 1'b1;
    endfunction

    // Sender: offer queued requests, each after its idle gap
    int        wait_left = -1;
    t_step_req cur_req;

    always @(posedge i_clk) begin : drive_proc
        logic      nv;
        t_pose_res exp_res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            wait_left = -1;
        end else begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                if (project_step(cur_req, exp_res)) residual_q.push_back(exp_res);
                nv = 1'b0;
                wait_left = -1;
            end
            if (!nv && step_q.size() > 0) begin
                if (wait_left < 0) wait_left = step_q[0].gap;
                if (wait_left > 0) begin
                    wait_left--;
                end else if (!step_q[0].drain || residual_q.size() == 0) begin
                    cur_req = step_q.pop_front();
                    s_axis_tdata <= {cur_req.ry, cur_req.rx, cur_req.yaw, cur_req.sy, cur_req.sx};
                    s_axis_tuser <= cur_req.first;
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // Receiver: check each residual against the oldest prediction, stall at random
    int stall_left = 0;

    always @(posedge i_clk) begin : watch_proc
        logic      nr;
        t_pose_res got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            nr = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.idx   = m_axis_tdata[9:0];
                got.res_x = m_axis_tdata[41:10];
                got.res_y = m_axis_tdata[73:42];
                got.yaw_x = m_axis_tdata[105:74];
                got.yaw_y = m_axis_tdata[137:106];
                got.cos_v = m_axis_tdata[153:138];
                got.sin_v = m_axis_tdata[169:154];
                if (residual_q.size() == 0) begin
                    flag_mismatch("unexpected result, step_index", got.idx, 0);
                end else begin
                    want = residual_q.pop_front();
                    if (got.idx !== want.idx)
                        flag_mismatch("step_index", got.idx, want.idx);
                    if (got.res_x !== want.res_x)
                        flag_mismatch("residual_x", got.res_x, want.res_x);
                    if (got.res_y !== want.res_y)
                        flag_mismatch("residual_y", got.res_y, want.res_y);
                    if (got.yaw_x !== want.yaw_x)
                        flag_mismatch("yaw_term_x", got.yaw_x, want.yaw_x);
                    if (got.yaw_y !== want.yaw_y)
                        flag_mismatch("yaw_term_y", got.yaw_y, want.yaw_y);
                    if (got.cos_v !== want.cos_v)
                        flag_mismatch("cos_prev_yaw", got.cos_v, want.cos_v);
                    if (got.sin_v !== want.sin_v)
                        flag_mismatch("sin_prev_yaw", got.sin_v, want.sin_v);
                    if (m_axis_tdata[175:170] !== 6'd0)
                        flag_mismatch("zero fill", m_axis_tdata[175:170], 0);
                end
                n_results++;
                // keep a calm stretch now and then, otherwise draw a stall
                stall_left = ((n_results / 120) % 5 == 3) ? 0 : $urandom_range(0, 7);
                nr = (stall_left == 0);
            end else if (!m_axis_tready) begin
                if (stall_left > 0) stall_left--;
                if (stall_left == 0) nr = 1'b1;
            end
            m_axis_tready <= nr;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("FAIL planar_step_pose_residual_core");
            $finish;
        end
    end

    task automatic push_step(input logic first, input logic signed [POS_W-1:0] sx,
                             input logic signed [POS_W-1:0] sy, input logic [YAW_W-1:0] yaw,
                             input logic signed [POS_W-1:0] rx,
                             input logic signed [POS_W-1:0] ry, input bit drain);
        t_step_req rq;
        rq.first = first; rq.sx = sx; rq.sy = sy; rq.yaw = yaw;
        rq.rx = rx; rq.ry = ry; rq.drain = drain;
        rq.gap = ((n_queued / 150) % 5 == 4) ? 0 : $urandom_range(0, 7);
        step_q.push_back(rq);
        n_queued++;
    endtask

    // Mostly moderate positions, some full range, a few extremes
    function automatic logic signed [POS_W-1:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return POS_W'(int'($urandom_range(0, 2097152)) - 1048576);
        if (r < 90) return POS_W'($urandom);
        case ($urandom_range(0, 5))
            0: return P_MAX;
            1: return P_MIN;
            2: return '0;
            3: return -1;
            4: return ONE_M;
            default: return -ONE_M;
        endcase
    endfunction

    function automatic logic [YAW_W-1:0] pick_yaw();
        if ($urandom_range(0, 9) != 0) return YAW_W'($urandom_range(0, 65535));
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd8191;
            2: return 16'd8192;
            3: return 16'd16383;
            4: return 16'd16384;
            5: return 16'd32767;
            6: return 16'd32768;
            7: return 16'd49152;
            8: return 16'd57344;
            default: return 16'd65535;
        endcase
    endfunction

    initial begin : stim_proc
        int  plen;
        bit  long_done;
        bit  fs;
        long_done = 0;

        // No stored pose yet: the first request only loads it
        push_step(1'b0, 32'sh00030000, 32'sh00020000, 16'd0, 32'sh00008000, '0, 0);
        // Walk the yaw through the quadrant fold boundaries
        push_step(1'b0, 32'sh00038000, 32'sh00020000, 16'd8191, 32'sh00008000, '0, 0);
        push_step(1'b0, 32'sh00040000, 32'sh00024000, 16'd8192, 32'sh00008000, ONE_M, 0);
        push_step(1'b0, 32'sh00044000, 32'sh00030000, 16'd16383, -ONE_M, 32'sh00004000, 0);
        push_step(1'b0, 32'sh00040000, 32'sh00038000, 16'd16384, 32'sh00008000, -ONE_M, 0);
        push_step(1'b0, 32'sh00038000, 32'sh00040000, 16'd24576, ONE_M, ONE_M, 0);
        push_step(1'b0, 32'sh00030000, 32'sh00038000, 16'd32768, 32'sh00008000, '0, 0);
        push_step(1'b0, 32'sh00028000, 32'sh00030000, 16'd40960, -ONE_M, -ONE_M, 0);
        push_step(1'b0, 32'sh00020000, 32'sh00028000, 16'd49152, 32'sh00004000, ONE_M, 0);
        push_step(1'b0, 32'sh00020000, 32'sh00020000, 16'd57343, ONE_M, 32'sh00008000, 0);
        push_step(1'b0, 32'sh00024000, 32'sh00018000, 16'd57344, ONE_M, '0, 0);
        push_step(1'b0, 32'sh00028000, 32'sh00010000, 16'd65535, 32'sh00008000, -1, 0);
        push_step(1'b0, 32'sh0002C000, 32'sh00010000, 16'd0, 32'sh00004000, 1, 0);
        // Field extremes, driving the sums into saturation both ways
        push_step(1'b0, P_MAX, P_MIN, 16'd12345, P_MIN, P_MIN, 0);
        push_step(1'b0, P_MIN, P_MAX, 16'd32768, P_MAX, P_MAX, 0);
        push_step(1'b0, P_MAX, P_MIN, 16'd16384, P_MIN, P_MAX, 0);
        // New plan mid-stream: store only, index restarts
        push_step(1'b1, P_MIN, P_MIN, 16'd65535, P_MAX, P_MAX, 0);
        push_step(1'b0, P_MAX, P_MAX, 16'd0, P_MIN, P_MIN, 0);
        push_step(1'b1, '0, '0, 16'd0, '0, '0, 0);
        push_step(1'b1, '0, '0, 16'd0, '0, '0, 0);
        push_step(1'b0, '0, '0, 16'd49152, '0, '0, 0);
        push_step(1'b0, -1, -1, 16'd65535, -1, -1, 1);

        // Random plans; one long plan drives the step index into its cap
        while (n_queued < N_RANDOM) begin
            if (!long_done && n_queued > 300) begin
                plen = STEP_CAP + 80;
                long_done = 1;
            end else begin
                plen = $urandom_range(1, 24);
            end
            for (int k = 0; k < plen; k++) begin
                // Mostly well-formed plans; now and then a missing or stray plan start
                fs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
                if (plen > 100 && k > 0) fs = 1'b0;
                push_step(fs, pick_pos(), pick_pos(), pick_yaw(), pick_pos(), pick_pos(),
                          n_queued == 1000);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests taken, all residuals back, then let the pipe settle
        while (step_q.size() > 0 || s_axis_tvalid || residual_q.size() > 0)
            @(posedge i_clk);
        repeat (64) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("PASS planar_step_pose_residual_core");
        end else begin
            $display("FAIL planar_step_pose_residual_core");
        end
        $finish;
    end

endmodule
